@@ rtl/sre_pkg.sv @@
// Shared types, constants and helpers for the static range encoder.
// No dependencies; every other file in rtl/ refers to this package.
package sre_pkg;

  localparam int COUNT_BITS = 32;
  localparam int SYM_W      = 8;
  localparam int IDX_W      = 9;
  localparam int WORD_W     = 32;
  localparam int TWORD_W    = 16;
  localparam int TOP_SHIFT  = 24;

  localparam logic [IDX_W-1:0]      LAST_IDX     = IDX_W'(256);
  localparam logic [WORD_W-1:0]     TOP_SPAN     = 32'h0100_0000;
  localparam logic [WORD_W-1:0]     RANGE_FLOOR  = 32'h0001_0000;
  localparam logic [WORD_W-1:0]     WORD_MAX     = 32'hFFFF_FFFF;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_COUNT  = 3'd1,
    OP_BUILD  = 3'd2,
    OP_READ   = 3'd3,
    OP_ENCODE = 3'd4,
    OP_FLUSH  = 3'd5
  } op_t;

  typedef enum logic [15:0] {
    ST_IDLE  = 16'h0001,
    ST_C_WR  = 16'h0002,
    ST_B_FRD = 16'h0004,
    ST_B_FWR = 16'h0008,
    ST_B_CHK = 16'h0010,
    ST_B_HRD = 16'h0020,
    ST_B_HWR = 16'h0040,
    ST_R_OUT = 16'h0080,
    ST_E_RD0 = 16'h0100,
    ST_E_RD1 = 16'h0200,
    ST_E_DIV = 16'h0400,
    ST_E_M1  = 16'h0800,
    ST_E_M2  = 16'h1000,
    ST_E_M3  = 16'h2000,
    ST_E_RN  = 16'h4000,
    ST_F_OUT = 16'h8000
  } state_t;

  // slot width of one symbol: empty symbols get one slot, big counts clamp
  function automatic logic [WORD_W-1:0] share_of(input logic [COUNT_BITS-1:0] h);
    logic [63:0] h64;
    h64 = 64'(h);
    if (h == '0) return WORD_W'(1);
    if (h64 > 64'(WORD_MAX)) return WORD_MAX;
    return WORD_W'(h);
  endfunction

endpackage

@@ rtl/sre_if.sv @@
// Request and result channel interfaces of the static range encoder.
// Depends on sre_pkg for field widths.
interface sre_in_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    operation;
  logic [sre_pkg::SYM_W-1:0]     symbol;
  logic [sre_pkg::IDX_W-1:0]     table_index;
  modport source (output valid, operation, symbol, table_index, input ready);
  modport sink   (input valid, operation, symbol, table_index, output ready);
endinterface

interface sre_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [7:0]                    byte_out;
  logic [sre_pkg::TWORD_W-1:0]   table_word;
  logic                          last;
  modport source (output valid, kind, byte_out, table_word, last, input ready);
  modport sink   (input valid, kind, byte_out, table_word, last, output ready);
endinterface

@@ rtl/sre_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on sre_pkg for the word width.
module sre_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sre_pkg::WORD_W-1:0]  dividend,
  input  logic [sre_pkg::WORD_W-1:0]  divisor,
  output logic [sre_pkg::WORD_W-1:0]  quotient,
  output logic                        done
);
  localparam int W = sre_pkg::WORD_W;

  logic [W-1:0]          rem;
  logic [W-1:0]          q;
  logic [W-1:0]          dvs;
  logic [$clog2(W+1)-1:0] cnt;
  logic [W:0]            trial;

  assign trial    = {rem, q[W-1]} - {1'b0, dvs};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q   <= dividend;
        dvs <= divisor;
        rem <= '0;
        cnt <= ($clog2(W+1))'(W);
      end else if (cnt != '0) begin
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          q   <= {q[W-2:0], 1'b1};
        end else begin
          rem <= {rem[W-2:0], q[W-1]};
          q   <= {q[W-2:0], 1'b0};
        end
        cnt  <= cnt - 1'b1;
        done <= (cnt == ($clog2(W+1))'(1));
      end
    end
  end
endmodule

@@ rtl/static_range_encoder.sv @@
// Static-model carryless range encoder, top level.
// Depends on sre_pkg, sre_if (sre_in_if, sre_out_if) and sre_div.
//
// Usage: requests arrive on cmd (operation, symbol, table_index); results
// leave on rsp (kind, byte_out, table_word, last), valid/ready on both.
// One request is taken at a time; cmd.ready is high only when the sequencer
// is idle. Results sit in an output register, so a new request is taken
// while the last result still waits for the receiver.
// Steps per request, from the accept on:
//   start ends at the accept; count writes the histogram; read and flush push results and wait on receiver stalls.
//   build: accept, the fill sweep (a histogram read and a table write per
//     entry) and a check, then per halving pass one read and one write of the table memory per entry and a check.
//   encode: accept, two table reads that overlap the divider start, the
//     rest of the divider run, the multiply states E_M1, E_M2 and E_M3, and
//     the renormalization loop, a pass per emitted byte and a final check.
// The divider and the single 32x32 multiplier are the shared units; the
// histogram and the table are single-write, single-read memories.
// Reset: histogram valid bits clear at once (no sweep), table not ready,
// low zero, range all ones. A stalled receiver stops the sequencer wherever
// a result must be pushed; nothing is dropped.
module static_range_encoder (
  input  logic          clk,
  input  logic          rst,
  sre_in_if.sink        cmd,
  sre_out_if.source     rsp
);
  localparam int W  = sre_pkg::WORD_W;
  localparam int CB = sre_pkg::COUNT_BITS;
  localparam int IW = sre_pkg::IDX_W;
  localparam int SW = sre_pkg::SYM_W;

  sre_pkg::state_t state;

  // memories
  logic [CB-1:0] hmem [0:(1<<SW)-1];
  logic [W-1:0]  tmem [0:(1<<IW)-1];
  logic [(1<<SW)-1:0] hvalid;
  logic [CB-1:0] hdata;
  logic          hv_q;
  logic [W-1:0]  tdata;

  logic [IW-1:0] taddr, t_waddr;
  logic [W-1:0]  t_wdata;
  logic          t_we;
  logic [SW-1:0] haddr;
  logic          h_we;

  // sequencer state
  logic [IW-1:0] i;
  logic [W-1:0]  prev, total;
  logic          table_ready;
  logic [W-1:0]  coder_low, coder_range;
  logic [SW-1:0] sym_q;
  logic [IW-1:0] idx_q;
  logic [W-1:0]  lo_e, hi_e, step, prod;
  logic [2:0]    n;
  logic [1:0]    fk;
  logic          pend_v;
  logic [7:0]    pend_byte;

  // output register
  logic          ov, o_kind, o_last;
  logic [7:0]    o_byte;
  logic [sre_pkg::TWORD_W-1:0] o_word;
  logic          out_free;
  logic          push, push_kind, push_last;
  logic [7:0]    push_byte;
  logic [sre_pkg::TWORD_W-1:0] push_word;

  logic          acc;
  logic [CB-1:0] h_cur;
  logic [W:0]    sum33;
  logic [W-1:0]  fill_sum, hv_half, halved;
  logic [W-1:0]  mul_a, mul_b, mul_p;
  logic          div_start, div_done;
  logic [W-1:0]  div_q;
  logic [W-1:0]  top_w, rn_range;
  logic          straddle, rn_done;

  assign cmd.ready      = (state == sre_pkg::ST_IDLE);
  assign acc            = cmd.valid && cmd.ready;
  assign out_free       = !ov || rsp.ready;
  assign rsp.valid      = ov;
  assign rsp.kind       = o_kind;
  assign rsp.byte_out   = o_byte;
  assign rsp.table_word = o_word;
  assign rsp.last       = o_last;

  // fill sweep: saturating running sum of slot widths
  assign h_cur    = hv_q ? hdata : '0;
  assign sum33    = {1'b0, prev} + {1'b0, sre_pkg::share_of(h_cur)};
  assign fill_sum = sum33[W] ? sre_pkg::WORD_MAX : sum33[W-1:0];
  // halving sweep: keep the table strictly rising
  assign hv_half  = tdata >> 1;
  assign halved   = (hv_half <= prev) ? prev + W'(1) : hv_half;

  // renormalization test on the current interval
  assign top_w    = coder_low + coder_range;
  assign straddle = (coder_low ^ top_w) >= sre_pkg::TOP_SPAN;
  assign rn_done  = (n == 3'd4) || (straddle && coder_range >= sre_pkg::RANGE_FLOOR);
  assign rn_range = straddle ? ((W'(0) - coder_low) & (sre_pkg::RANGE_FLOOR - W'(1)))
                             : coder_range;

  assign mul_p = mul_a * mul_b;

  sre_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (coder_range),
    .divisor  (total),
    .quotient (div_q),
    .done     (div_done)
  );

  always_comb begin
    taddr     = idx_q;
    haddr     = sym_q;
    t_we      = 1'b0;
    t_waddr   = i;
    t_wdata   = fill_sum;
    h_we      = 1'b0;
    push      = 1'b0;
    push_kind = 1'b0;
    push_byte = '0;
    push_word = '0;
    push_last = 1'b0;
    mul_a     = lo_e;
    mul_b     = step;
    div_start = 1'b0;
    case (state)
      sre_pkg::ST_IDLE: begin
        taddr = (cmd.operation == sre_pkg::OP_ENCODE) ? IW'(cmd.symbol) : cmd.table_index;
        haddr = cmd.symbol;
        if (acc && cmd.operation == sre_pkg::OP_BUILD) begin
          t_we    = 1'b1;
          t_waddr = '0;
          t_wdata = '0;
        end
      end
      sre_pkg::ST_C_WR:  h_we = (h_cur != sre_pkg::COUNT_MAX);
      sre_pkg::ST_B_FRD: haddr = SW'(i - IW'(1));
      sre_pkg::ST_B_FWR: t_we = 1'b1;
      sre_pkg::ST_B_HRD: taddr = i;
      sre_pkg::ST_B_HWR: begin
        t_we    = 1'b1;
        t_wdata = halved;
      end
      sre_pkg::ST_R_OUT: begin
        push      = out_free;
        push_kind = 1'b1;
        push_word = tdata[sre_pkg::TWORD_W-1:0];
        push_last = 1'b1;
      end
      sre_pkg::ST_E_RD0: begin
        taddr     = IW'(sym_q) + IW'(1);
        div_start = 1'b1;
      end
      sre_pkg::ST_E_M2: mul_a = hi_e - lo_e;
      sre_pkg::ST_E_RN: begin
        // a byte is held back one step so its last flag is known
        push      = pend_v && out_free;
        push_byte = pend_byte;
        push_last = rn_done;
      end
      sre_pkg::ST_F_OUT: begin
        push      = out_free;
        push_byte = 8'(coder_low >> sre_pkg::TOP_SHIFT);
        push_last = (fk == 2'd3);
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (h_we) hmem[sym_q] <= h_cur + CB'(1);
    hdata <= hmem[haddr];
    if (t_we) tmem[t_waddr] <= t_wdata;
    tdata <= tmem[taddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid <= '0;
      hv_q   <= 1'b0;
    end else begin
      hv_q <= hvalid[haddr];
      if (acc && cmd.operation == sre_pkg::OP_START) hvalid <= '0;
      else if (state == sre_pkg::ST_C_WR) hvalid[sym_q] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (push) begin
      ov     <= 1'b1;
      o_kind <= push_kind;
      o_byte <= push_byte;
      o_word <= push_word;
      o_last <= push_last;
    end else if (rsp.ready) begin
      ov <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sre_pkg::ST_IDLE;
      table_ready <= 1'b0;
      coder_low   <= '0;
      coder_range <= sre_pkg::WORD_MAX;
      pend_v      <= 1'b0;
    end else begin
      case (state)
        sre_pkg::ST_IDLE: begin
          if (acc) begin
            sym_q <= cmd.symbol;
            idx_q <= cmd.table_index;
            case (cmd.operation)
              sre_pkg::OP_START: begin
                table_ready <= 1'b0;
                coder_low   <= '0;
                coder_range <= sre_pkg::WORD_MAX;
              end
              sre_pkg::OP_COUNT: state <= sre_pkg::ST_C_WR;
              sre_pkg::OP_BUILD: begin
                prev  <= '0;
                i     <= IW'(1);
                state <= sre_pkg::ST_B_FRD;
              end
              sre_pkg::OP_READ: begin
                if (table_ready && cmd.table_index <= sre_pkg::LAST_IDX)
                  state <= sre_pkg::ST_R_OUT;
              end
              sre_pkg::OP_ENCODE: begin
                if (table_ready) state <= sre_pkg::ST_E_RD0;
              end
              sre_pkg::OP_FLUSH: begin
                fk    <= '0;
                state <= sre_pkg::ST_F_OUT;
              end
              default: ;
            endcase
          end
        end
        sre_pkg::ST_C_WR:  state <= sre_pkg::ST_IDLE;
        sre_pkg::ST_B_FRD: state <= sre_pkg::ST_B_FWR;
        sre_pkg::ST_B_FWR: begin
          prev <= fill_sum;
          if (i == sre_pkg::LAST_IDX) begin
            total <= fill_sum;
            state <= sre_pkg::ST_B_CHK;
          end else begin
            i     <= i + IW'(1);
            state <= sre_pkg::ST_B_FRD;
          end
        end
        sre_pkg::ST_B_CHK: begin
          if (total >= sre_pkg::RANGE_FLOOR) begin
            prev  <= '0;
            i     <= IW'(1);
            state <= sre_pkg::ST_B_HRD;
          end else begin
            table_ready <= 1'b1;
            state       <= sre_pkg::ST_IDLE;
          end
        end
        sre_pkg::ST_B_HRD: state <= sre_pkg::ST_B_HWR;
        sre_pkg::ST_B_HWR: begin
          prev <= halved;
          if (i == sre_pkg::LAST_IDX) begin
            total <= halved;
            state <= sre_pkg::ST_B_CHK;
          end else begin
            i     <= i + IW'(1);
            state <= sre_pkg::ST_B_HRD;
          end
        end
        sre_pkg::ST_R_OUT: if (out_free) state <= sre_pkg::ST_IDLE;
        sre_pkg::ST_E_RD0: begin
          lo_e  <= tdata;
          state <= sre_pkg::ST_E_RD1;
        end
        sre_pkg::ST_E_RD1: begin
          hi_e  <= tdata;
          state <= sre_pkg::ST_E_DIV;
        end
        sre_pkg::ST_E_DIV: begin
          if (div_done) begin
            step  <= div_q;
            state <= sre_pkg::ST_E_M1;
          end
        end
        sre_pkg::ST_E_M1: begin
          prod  <= mul_p;
          state <= sre_pkg::ST_E_M2;
        end
        sre_pkg::ST_E_M2: begin
          coder_low <= coder_low + prod;
          prod      <= mul_p;
          state     <= sre_pkg::ST_E_M3;
        end
        sre_pkg::ST_E_M3: begin
          coder_range <= prod;
          n           <= '0;
          state       <= sre_pkg::ST_E_RN;
        end
        sre_pkg::ST_E_RN: begin
          if (rn_done) begin
            if (!pend_v || out_free) begin
              pend_v <= 1'b0;
              state  <= sre_pkg::ST_IDLE;
            end
          end else if (!pend_v || out_free) begin
            pend_v      <= 1'b1;
            pend_byte   <= 8'(coder_low >> sre_pkg::TOP_SHIFT);
            coder_range <= rn_range << 8;
            coder_low   <= coder_low << 8;
            n           <= n + 3'd1;
          end
        end
        sre_pkg::ST_F_OUT: begin
          if (out_free) begin
            coder_low <= coder_low << 8;
            fk        <= fk + 2'd1;
            if (fk == 2'd3) begin
              coder_range <= sre_pkg::WORD_MAX;
              state       <= sre_pkg::ST_IDLE;
            end
          end
        end
        default: state <= sre_pkg::ST_IDLE;
      endcase
    end
  end

  // held-back byte only lives inside the renormalization loop
  a_pend_in_rn: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> state == sre_pkg::ST_E_RN)
    else $error("pending byte outside renormalization");

  a_rn_bound: assert property (@(posedge clk) disable iff (rst)
    (state == sre_pkg::ST_E_RN) |-> n <= 3'd4)
    else $error("more than four bytes for one symbol");

  a_table_scaled: assert property (@(posedge clk) disable iff (rst)
    (state == sre_pkg::ST_IDLE && table_ready) |-> total < sre_pkg::RANGE_FLOOR)
    else $error("table total not below range floor");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == sre_pkg::ST_E_DIV)
    else $error("divider finished outside encode");

  a_word_last: assert property (@(posedge clk) disable iff (rst)
    (push && push_kind) |=> (rsp.valid && rsp.last))
    else $error("table word result without last");

endmodule
